// ----- src/dqpi_pkg.sv -----
// ----------------------------------------------------------------------------
// dqpi_pkg
// Shared types and constants of the dq current PI controller with circular
// modulation limit.
// ----------------------------------------------------------------------------
package dqpi_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int ACC_WIDTH    = 32;
   localparam int GAIN_WIDTH   = 16;
   localparam int RADIUS_WIDTH = 15;
   localparam int MOD_WIDTH    = 32;
   localparam int OUT_WIDTH    = 16;
   localparam int SQ_WIDTH     = 64;
   localparam int MAG_WIDTH    = 32;
   localparam int QUOT_WIDTH   = 16;
   localparam int SQRT_STEPS   = 32;
   localparam int DIV_STEPS    = 16;
   localparam int CNT_WIDTH    = 5;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [GAIN_WIDTH-1:0] DECAY_Q16 = 16'd64881;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_Q_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_Q_INT_GAIN   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_D_PROP_GAIN  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_D_INT_GAIN   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_VOLT_TO_MOD  = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MOD_RADIUS   = 3'd5;

   localparam logic [GAIN_WIDTH-1:0]   RST_PROP_GAIN = 16'd256;
   localparam logic [GAIN_WIDTH-1:0]   RST_INT_GAIN  = 16'd0;
   localparam logic [GAIN_WIDTH-1:0]   RST_SCALE     = 16'd4096;
   localparam logic [RADIUS_WIDTH-1:0] RST_RADIUS    = 15'd7094;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] q_target;
      logic signed [SAMPLE_WIDTH-1:0] d_target;
      logic signed [SAMPLE_WIDTH-1:0] q_measured;
      logic signed [SAMPLE_WIDTH-1:0] d_measured;
   } req_data_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] q_modulation;
      logic signed [OUT_WIDTH-1:0] d_modulation;
      logic                        limited;
   } rsp_data_type;

   typedef enum logic [3:0] {
      LOP_NONE,
      LOP_LOAD,
      LOP_MUL_KP,
      LOP_MUL_KI,
      LOP_SUM,
      LOP_MUL_SCALE,
      LOP_MOD,
      LOP_MUL_SQ,
      LOP_MUL_RAD,
      LOP_DIV_LOAD,
      LOP_DIV_STEP,
      LOP_MUL_DECAY,
      LOP_DECAY,
      LOP_ACCUM
   } lane_op_type;

   typedef struct packed {
      lane_op_type op;
   } lane_ctl_type;

   typedef struct packed {
      logic sum_load;
      logic sqrt_load;
      logic sqrt_step;
   } merge_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_KP,
      ST_MUL_KI,
      ST_SUM,
      ST_MUL_SCALE,
      ST_MOD,
      ST_MUL_SQ,
      ST_TEST,
      ST_CMP,
      ST_SQRT,
      ST_DIV_LOAD,
      ST_DIV,
      ST_MUL_DECAY,
      ST_DECAY,
      ST_ACCUM,
      ST_OUT
   } state_type;

endpackage

// ----- src/dqpi_lane.sv -----
// ----------------------------------------------------------------------------
// dqpi_lane
// One axis of the controller: error, PI voltage, modulation, square, scaling
// divider and integrator, sharing one registered multiplier.
// ----------------------------------------------------------------------------
module dqpi_lane #(
   parameter int ACC_WIDTH = dqpi_pkg::ACC_WIDTH
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  dqpi_pkg::lane_ctl_type                       ctl,
   input  logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]     target,
   input  logic signed [dqpi_pkg::SAMPLE_WIDTH-1:0]     measured,
   input  logic        [dqpi_pkg::GAIN_WIDTH-1:0]       prop_gain,
   input  logic        [dqpi_pkg::GAIN_WIDTH-1:0]       int_gain,
   input  logic        [dqpi_pkg::GAIN_WIDTH-1:0]       scale,
   input  logic        [dqpi_pkg::RADIUS_WIDTH-1:0]     radius,
   input  logic        [dqpi_pkg::MAG_WIDTH-1:0]        mag,
   output logic        [dqpi_pkg::SQ_WIDTH-1:0]         mod_sq,
   output logic signed [dqpi_pkg::OUT_WIDTH-1:0]        mod_out,
   output logic signed [dqpi_pkg::OUT_WIDTH-1:0]        scaled_out
);

   localparam int EW  = dqpi_pkg::SAMPLE_WIDTH + 1;
   localparam int MW  = dqpi_pkg::MOD_WIDTH;
   localparam int AW  = (ACC_WIDTH > MW) ? ACC_WIDTH : MW;
   localparam int BW  = MW + 1;
   localparam int PW  = AW + BW;
   localparam int PW1 = PW + 1;
   localparam int AC1 = ACC_WIDTH + 1;
   localparam int QW  = dqpi_pkg::QUOT_WIDTH;
   localparam int GW  = dqpi_pkg::MAG_WIDTH;
   localparam int OW  = dqpi_pkg::OUT_WIDTH;

   localparam logic signed [PW:0]    SUM_MAX = {{(PW-30){1'b0}}, {31{1'b1}}};
   localparam logic signed [PW:0]    SUM_MIN = {{(PW-30){1'b1}}, {31{1'b0}}};
   localparam logic signed [PW-1:0]  MOD_MAX = {{(PW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [PW-1:0]  MOD_MIN = {{(PW-31){1'b1}}, {31{1'b0}}};
   localparam logic signed [ACC_WIDTH:0] ACC_MAX = {2'b00, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH:0] ACC_MIN = {2'b11, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [MW-1:0]  OUT_MAX = {{(MW-15){1'b0}}, {15{1'b1}}};
   localparam logic signed [MW-1:0]  OUT_MIN = {{(MW-15){1'b1}}, {15{1'b0}}};

   logic signed [EW-1:0]        err_ff, err_in;
   logic signed [ACC_WIDTH-1:0] integ_ff, integ_in;
   logic signed [PW-1:0]        part_ff, part_in;
   logic signed [MW-1:0]        volt_ff, volt_in;
   logic signed [MW-1:0]        mod_ff, mod_in;
   logic signed [PW-1:0]        prod_ff, prod_in;
   logic        [GW-1:0]        rem_ff, rem_in;
   logic        [QW-1:0]        low_ff, low_in;
   logic        [QW-1:0]        quot_ff, quot_in;
   logic        [GW-1:0]        div_ff, div_in;

   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;
   logic signed [PW:0]   volt_sum;
   logic signed [PW-1:0] mod_shift;
   logic signed [PW-1:0] prod_abs;
   logic signed [PW-1:0] decay_adj;
   logic signed [ACC_WIDTH:0] acc_sum;
   logic        [GW:0]   rem_sh;

   always_comb begin
      unique case (ctl.op)
         dqpi_pkg::LOP_MUL_KP: begin
            mul_a = AW'(err_ff);
            mul_b = $signed({{(BW-16){1'b0}}, prop_gain});
         end
         dqpi_pkg::LOP_MUL_KI: begin
            mul_a = AW'(integ_ff);
            mul_b = $signed({{(BW-16){1'b0}}, int_gain});
         end
         dqpi_pkg::LOP_MUL_SCALE: begin
            mul_a = AW'(volt_ff);
            mul_b = $signed({{(BW-16){1'b0}}, scale});
         end
         dqpi_pkg::LOP_MUL_SQ: begin
            mul_a = AW'(mod_ff);
            mul_b = BW'(mod_ff);
         end
         dqpi_pkg::LOP_MUL_RAD: begin
            mul_a = AW'(mod_ff);
            mul_b = $signed({{(BW-dqpi_pkg::RADIUS_WIDTH){1'b0}}, radius});
         end
         dqpi_pkg::LOP_MUL_DECAY: begin
            mul_a = AW'(integ_ff);
            mul_b = $signed({{(BW-16){1'b0}}, dqpi_pkg::DECAY_Q16});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      volt_sum  = PW1'(part_ff) + PW1'(prod_ff >>> 8);
      mod_shift = prod_ff >>> 11;
      prod_abs  = (prod_ff < 0) ? -prod_ff : prod_ff;
      decay_adj = (prod_ff < 0) ? prod_ff + PW'(65535) : prod_ff;
      acc_sum   = AC1'(integ_ff) + AC1'(err_ff);
      rem_sh    = {rem_ff, low_ff[QW-1]};

      err_in   = err_ff;
      integ_in = integ_ff;
      part_in  = part_ff;
      volt_in  = volt_ff;
      mod_in   = mod_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;

      unique case (ctl.op)
         dqpi_pkg::LOP_LOAD: begin
            err_in = EW'(target) - EW'(measured);
         end
         dqpi_pkg::LOP_MUL_KP, dqpi_pkg::LOP_MUL_SCALE, dqpi_pkg::LOP_MUL_SQ,
         dqpi_pkg::LOP_MUL_RAD, dqpi_pkg::LOP_MUL_DECAY: begin
            prod_in = mul_a * mul_b;
         end
         dqpi_pkg::LOP_MUL_KI: begin
            part_in = prod_ff >>> 8;
            prod_in = mul_a * mul_b;
         end
         dqpi_pkg::LOP_SUM: begin
            priority if (volt_sum > SUM_MAX) begin
               volt_in = {1'b0, {(MW-1){1'b1}}};
            end else if (volt_sum < SUM_MIN) begin
               volt_in = {1'b1, {(MW-1){1'b0}}};
            end else begin
               volt_in = volt_sum[MW-1:0];
            end
         end
         dqpi_pkg::LOP_MOD: begin
            priority if (mod_shift > MOD_MAX) begin
               mod_in = {1'b0, {(MW-1){1'b1}}};
            end else if (mod_shift < MOD_MIN) begin
               mod_in = {1'b1, {(MW-1){1'b0}}};
            end else begin
               mod_in = mod_shift[MW-1:0];
            end
         end
         dqpi_pkg::LOP_DIV_LOAD: begin
            rem_in  = prod_abs[GW+QW-1:QW];
            low_in  = prod_abs[QW-1:0];
            quot_in = '0;
            div_in  = (mag == '0) ? GW'(1) : mag;
         end
         dqpi_pkg::LOP_DIV_STEP: begin
            low_in = {low_ff[QW-2:0], 1'b0};
            if (rem_sh >= {1'b0, div_ff}) begin
               rem_in  = GW'(rem_sh - {1'b0, div_ff});
               quot_in = {quot_ff[QW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh[GW-1:0];
               quot_in = {quot_ff[QW-2:0], 1'b0};
            end
         end
         dqpi_pkg::LOP_DECAY: begin
            integ_in = ACC_WIDTH'(decay_adj >>> 16);
         end
         dqpi_pkg::LOP_ACCUM: begin
            priority if (acc_sum > ACC_MAX) begin
               integ_in = {1'b0, {(ACC_WIDTH-1){1'b1}}};
            end else if (acc_sum < ACC_MIN) begin
               integ_in = {1'b1, {(ACC_WIDTH-1){1'b0}}};
            end else begin
               integ_in = acc_sum[ACC_WIDTH-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else begin
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff  <= err_in;
      part_ff <= part_in;
      volt_ff <= volt_in;
      mod_ff  <= mod_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   always_comb begin
      mod_sq = prod_ff[dqpi_pkg::SQ_WIDTH-1:0];
      priority if (mod_ff > OUT_MAX) begin
         mod_out = {1'b0, {(OW-1){1'b1}}};
      end else if (mod_ff < OUT_MIN) begin
         mod_out = {1'b1, {(OW-1){1'b0}}};
      end else begin
         mod_out = mod_ff[OW-1:0];
      end
      scaled_out = mod_ff[MW-1] ? -$signed(quot_ff) : $signed(quot_ff);
   end

endmodule

// ----- src/dqpi_merge.sv -----
// ----------------------------------------------------------------------------
// dqpi_merge
// Combines the two lanes: sum of squares, limit test against the radius and
// a bit-serial square root of the sum of squares, giving the magnitude.
// ----------------------------------------------------------------------------
module dqpi_merge (
   input  logic                                   clock,
   input  logic                                   reset,
   input  dqpi_pkg::merge_ctl_type                ctl,
   input  logic [dqpi_pkg::SQ_WIDTH-1:0]          q_sq,
   input  logic [dqpi_pkg::SQ_WIDTH-1:0]          d_sq,
   input  logic [dqpi_pkg::RADIUS_WIDTH-1:0]      radius,
   output logic                                   over,
   output logic                                   limited,
   output logic [dqpi_pkg::MAG_WIDTH-1:0]         mag
);

   localparam int SW = dqpi_pkg::SQ_WIDTH;
   localparam int RW = 2 * dqpi_pkg::RADIUS_WIDTH;

   logic [SW-1:0] sum_ff, sum_in;
   logic [RW-1:0] radsq_ff;
   logic          lim_ff, lim_in;
   logic [SW-1:0] v_ff, v_in;
   logic [SW-1:0] res_ff, res_in;
   logic [SW-1:0] bit_ff, bit_in;
   logic [SW-1:0] trial;

   always_comb begin
      over   = sum_ff > {{(SW-RW){1'b0}}, radsq_ff};
      trial  = res_ff + bit_ff;
      sum_in = sum_ff;
      lim_in = lim_ff;
      v_in   = v_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (ctl.sum_load) begin
         sum_in = q_sq + d_sq;
      end
      if (ctl.sqrt_load) begin
         lim_in = over;
         v_in   = sum_ff;
         res_in = '0;
         bit_in = {2'b01, {(SW-2){1'b0}}};
      end else if (ctl.sqrt_step) begin
         bit_in = bit_ff >> 2;
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= 1'b0;
      end else begin
         lim_ff <= lim_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      radsq_ff <= radius * radius;
      v_ff     <= v_in;
      res_ff   <= res_in;
      bit_ff   <= bit_in;
   end

   assign limited = lim_ff;
   assign mag     = res_ff[dqpi_pkg::MAG_WIDTH-1:0];

endmodule

// ----- src/dq_current_pi_voltage_circle_limit.sv -----
// ----------------------------------------------------------------------------
// dq_current_pi_voltage_circle_limit
// Sequence: error, PI voltage, modulation and square, then the circle test;
// a limited vector also passes the 32-step square root and the 16-step
// divider per lane. A new transfer is taken once the sequencer is back in
// idle, while a result may still wait on the output; transfers do not
// overlap.
// Reset: synchronous; registers to defaults, both integrals cleared.
// ----------------------------------------------------------------------------
module dq_current_pi_voltage_circle_limit #(
   parameter int ACC_WIDTH = dqpi_pkg::ACC_WIDTH
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  dqpi_pkg::req_data_type                   req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output dqpi_pkg::rsp_data_type                   rsp_data,
   input  logic                                     csr_wr_en,
   input  logic [dqpi_pkg::CSR_IDX_WIDTH-1:0]       csr_index,
   input  logic [dqpi_pkg::GAIN_WIDTH-1:0]          csr_wr_data
);

   dqpi_pkg::state_type state_ff, state_in;
   logic [dqpi_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;

   logic [dqpi_pkg::GAIN_WIDTH-1:0]   q_prop_ff, q_int_ff, d_prop_ff, d_int_ff, scale_ff;
   logic [dqpi_pkg::RADIUS_WIDTH-1:0] radius_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   dqpi_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   dqpi_pkg::lane_ctl_type  lane_ctl;
   dqpi_pkg::merge_ctl_type merge_ctl;

   logic [dqpi_pkg::SQ_WIDTH-1:0]         q_sq, d_sq;
   logic signed [dqpi_pkg::OUT_WIDTH-1:0] q_mod, d_mod, q_scaled, d_scaled;
   logic                                  over, limited;
   logic [dqpi_pkg::MAG_WIDTH-1:0]        mag;
   logic                                  req_xfer, out_free;

   assign req_xfer = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_prop_ff <= dqpi_pkg::RST_PROP_GAIN;
         q_int_ff  <= dqpi_pkg::RST_INT_GAIN;
         d_prop_ff <= dqpi_pkg::RST_PROP_GAIN;
         d_int_ff  <= dqpi_pkg::RST_INT_GAIN;
         scale_ff  <= dqpi_pkg::RST_SCALE;
         radius_ff <= dqpi_pkg::RST_RADIUS;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            dqpi_pkg::CSR_Q_PROP_GAIN: q_prop_ff <= csr_wr_data;
            dqpi_pkg::CSR_Q_INT_GAIN:  q_int_ff  <= csr_wr_data;
            dqpi_pkg::CSR_D_PROP_GAIN: d_prop_ff <= csr_wr_data;
            dqpi_pkg::CSR_D_INT_GAIN:  d_int_ff  <= csr_wr_data;
            dqpi_pkg::CSR_VOLT_TO_MOD: scale_ff  <= csr_wr_data;
            dqpi_pkg::CSR_MOD_RADIUS:  radius_ff <= csr_wr_data[dqpi_pkg::RADIUS_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      lane_ctl.op  = dqpi_pkg::LOP_NONE;
      merge_ctl    = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         dqpi_pkg::ST_IDLE: begin
            if (req_xfer) begin
               lane_ctl.op = dqpi_pkg::LOP_LOAD;
               state_in    = dqpi_pkg::ST_MUL_KP;
            end
         end
         dqpi_pkg::ST_MUL_KP: begin
            lane_ctl.op = dqpi_pkg::LOP_MUL_KP;
            state_in    = dqpi_pkg::ST_MUL_KI;
         end
         dqpi_pkg::ST_MUL_KI: begin
            lane_ctl.op = dqpi_pkg::LOP_MUL_KI;
            state_in    = dqpi_pkg::ST_SUM;
         end
         dqpi_pkg::ST_SUM: begin
            lane_ctl.op = dqpi_pkg::LOP_SUM;
            state_in    = dqpi_pkg::ST_MUL_SCALE;
         end
         dqpi_pkg::ST_MUL_SCALE: begin
            lane_ctl.op = dqpi_pkg::LOP_MUL_SCALE;
            state_in    = dqpi_pkg::ST_MOD;
         end
         dqpi_pkg::ST_MOD: begin
            lane_ctl.op = dqpi_pkg::LOP_MOD;
            state_in    = dqpi_pkg::ST_MUL_SQ;
         end
         dqpi_pkg::ST_MUL_SQ: begin
            lane_ctl.op = dqpi_pkg::LOP_MUL_SQ;
            state_in    = dqpi_pkg::ST_TEST;
         end
         dqpi_pkg::ST_TEST: begin
            merge_ctl.sum_load = 1'b1;
            state_in           = dqpi_pkg::ST_CMP;
         end
         dqpi_pkg::ST_CMP: begin
            merge_ctl.sqrt_load = 1'b1;
            lane_ctl.op         = dqpi_pkg::LOP_MUL_RAD;
            cnt_in              = '0;
            state_in            = over ? dqpi_pkg::ST_SQRT : dqpi_pkg::ST_ACCUM;
         end
         dqpi_pkg::ST_SQRT: begin
            merge_ctl.sqrt_step = 1'b1;
            cnt_in              = cnt_ff + 1'b1;
            if (cnt_ff == dqpi_pkg::CNT_WIDTH'(dqpi_pkg::SQRT_STEPS - 1)) begin
               state_in = dqpi_pkg::ST_DIV_LOAD;
            end
         end
         dqpi_pkg::ST_DIV_LOAD: begin
            lane_ctl.op = dqpi_pkg::LOP_DIV_LOAD;
            cnt_in      = '0;
            state_in    = dqpi_pkg::ST_DIV;
         end
         dqpi_pkg::ST_DIV: begin
            lane_ctl.op = dqpi_pkg::LOP_DIV_STEP;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == dqpi_pkg::CNT_WIDTH'(dqpi_pkg::DIV_STEPS - 1)) begin
               state_in = dqpi_pkg::ST_MUL_DECAY;
            end
         end
         dqpi_pkg::ST_MUL_DECAY: begin
            lane_ctl.op = dqpi_pkg::LOP_MUL_DECAY;
            state_in    = dqpi_pkg::ST_DECAY;
         end
         dqpi_pkg::ST_DECAY: begin
            lane_ctl.op = dqpi_pkg::LOP_DECAY;
            state_in    = dqpi_pkg::ST_OUT;
         end
         dqpi_pkg::ST_ACCUM: begin
            lane_ctl.op = dqpi_pkg::LOP_ACCUM;
            state_in    = dqpi_pkg::ST_OUT;
         end
         dqpi_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.limited       = limited;
               rsp_data_in.q_modulation  = limited ? q_scaled : q_mod;
               rsp_data_in.d_modulation  = limited ? d_scaled : d_mod;
               state_in                  = dqpi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dqpi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dqpi_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != dqpi_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   dqpi_lane #(.ACC_WIDTH(ACC_WIDTH)) u_q_lane (
      .clock      (clock),
      .reset      (reset),
      .ctl        (lane_ctl),
      .target     (req_data.q_target),
      .measured   (req_data.q_measured),
      .prop_gain  (q_prop_ff),
      .int_gain   (q_int_ff),
      .scale      (scale_ff),
      .radius     (radius_ff),
      .mag        (mag),
      .mod_sq     (q_sq),
      .mod_out    (q_mod),
      .scaled_out (q_scaled)
   );

   dqpi_lane #(.ACC_WIDTH(ACC_WIDTH)) u_d_lane (
      .clock      (clock),
      .reset      (reset),
      .ctl        (lane_ctl),
      .target     (req_data.d_target),
      .measured   (req_data.d_measured),
      .prop_gain  (d_prop_ff),
      .int_gain   (d_int_ff),
      .scale      (scale_ff),
      .radius     (radius_ff),
      .mag        (mag),
      .mod_sq     (d_sq),
      .mod_out    (d_mod),
      .scaled_out (d_scaled)
   );

   dqpi_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .ctl     (merge_ctl),
      .q_sq    (q_sq),
      .d_sq    (d_sq),
      .radius  (radius_ff),
      .over    (over),
      .limited (limited),
      .mag     (mag)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("transfer accepted without leaving idle");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.limited |->
         ($signed(rsp_data.q_modulation) <= $signed({1'b0, radius_ff})) &&
         ($signed(rsp_data.q_modulation) >= -$signed({1'b0, radius_ff})))
      else $error("limited q component outside circle");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == dqpi_pkg::ST_OUT) && out_free |=> rsp_valid && !req_stall)
      else $error("result not presented on completion");

endmodule
